FILE: src/ets_pkg.sv
// ----------------------------------------------------------------------------
// ets_pkg
// Shared constants, command and status types and the month table for the
// seconds-to-calendar converter.
// ----------------------------------------------------------------------------
package ets_pkg;

  localparam int DAY_SECONDS  = 86400;
  localparam int MIN_SECONDS  = 60;
  localparam int HOUR_SECONDS = 3600;
  localparam int FIRST_YEAR   = 1970;
  localparam int COMMON_DAYS  = 365;
  localparam int LEAP_DAYS    = 366;

  // 1970 mod 4, mod 100 and mod 400.
  localparam int FIRST_MOD4   = 2;
  localparam int FIRST_MOD100 = 70;
  localparam int FIRST_MOD400 = 370;

  // 86400 is 128 * 675, so floor(x / 86400) ==
  // ((x >> DAY_PRE_SHIFT) * DAY_RECIP) >> DAY_SHIFT for any 32-bit x.
  localparam int DAY_PRE_SHIFT = 7;
  localparam int DAY_RECIP     = 50903317;
  localparam int DAY_SHIFT     = 35;

  // floor(x / 60) == (x * MIN_RECIP) >> MIN_SHIFT for x < 86400.
  localparam int MIN_RECIP  = 139811;
  localparam int MIN_SHIFT  = 23;
  // floor(x / 60) == (x * HOUR_RECIP) >> HOUR_SHIFT for x < 1440.
  localparam int HOUR_RECIP = 1093;
  localparam int HOUR_SHIFT = 16;

  localparam int LAST_MONTH = 11;
  localparam int FEB_INDEX  = 1;

  localparam logic OFFSET_REG_IDX = 1'b0;

  typedef struct packed {
    logic load;
    logic day_div;
    logic sod_calc;
    logic hms1;
    logic hms2;
    logic hms3;
    logic year_step;
    logic month_step;
    logic out_load;
  } ets_cmd_t;

  typedef struct packed {
    logic year_done;
    logic month_found;
  } ets_sts_t;

  // Days before the start of each month in a common year.
  function automatic logic [8:0] month_start(input logic [3:0] m);
    logic [8:0] d;
    case (m)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

FILE: src/ets_ctrl.sv
// ----------------------------------------------------------------------------
// ets_ctrl
// Sequencer: accepts a word, steps the datapath through the day division,
// the time-of-day split, the year walk and the month search, then hands the
// result to the output register.
// ----------------------------------------------------------------------------
module ets_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  ets_pkg::ets_sts_t sts,
  output ets_pkg::ets_cmd_t cmd
);
  import ets_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DAY, S_SOD, S_HMS1, S_HMS2, S_HMS3, S_YEAR, S_MONTH, S_FINISH
  } state_t;

  state_t     state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    cmd            = '0;
    state_nxt      = state_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DAY;
        end
      end
      S_DAY: begin
        cmd.day_div = 1'b1;
        state_nxt   = S_SOD;
      end
      S_SOD: begin
        cmd.sod_calc = 1'b1;
        state_nxt    = S_HMS1;
      end
      S_HMS1: begin
        cmd.hms1  = 1'b1;
        state_nxt = S_HMS2;
      end
      S_HMS2: begin
        cmd.hms2  = 1'b1;
        state_nxt = S_HMS3;
      end
      S_HMS3: begin
        cmd.hms3  = 1'b1;
        state_nxt = S_YEAR;
      end
      S_YEAR: begin
        if (sts.year_done) begin
          state_nxt = S_MONTH;
        end else begin
          cmd.year_step = 1'b1;
        end
      end
      S_MONTH: begin
        cmd.month_step = 1'b1;
        if (sts.month_found) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: src/ets_dp.sv
// ----------------------------------------------------------------------------
// ets_dp
// Datapath: zone offset with saturation, reciprocal division by the day
// length, reciprocal split of the second of day, year walk with modulo
// counters, month search and the output register.
// ----------------------------------------------------------------------------
module ets_dp (
  input  logic              clk,
  input  ets_pkg::ets_cmd_t cmd,
  output ets_pkg::ets_sts_t sts,
  input  logic signed [4:0] offset_hours,
  input  logic [31:0]       in_epoch_seconds,
  output logic [11:0]       out_year,
  output logic [3:0]        out_month,
  output logic [4:0]        out_day,
  output logic [4:0]        out_hour,
  output logic [5:0]        out_minute,
  output logic [5:0]        out_second
);
  import ets_pkg::*;

  logic signed [16:0] off_sec;
  logic signed [33:0] local_sum;
  logic [31:0]        local_t;

  logic [31:0] lt_r;
  logic [50:0] prod_day;
  logic [31:0] day_start;
  logic [16:0] rem_r;
  logic [15:0] quo_r;

  logic [34:0] prod_min;
  logic [21:0] prod_hour;
  logic [10:0] mins_r;
  logic [4:0]  hour_r;
  logic [5:0]  sec_r;
  logic [5:0]  min_r;
  logic [16:0] sec_full;
  logic [10:0] min_full;

  logic [11:0] year_r;
  logic [1:0]  c4_r;
  logic [6:0]  c100_r;
  logic [8:0]  c400_r;
  logic        leap;
  logic [8:0]  year_len;

  logic [3:0]  mon_r;
  logic [8:0]  mstart;

  logic [11:0] out_year_r;
  logic [3:0]  out_month_r;
  logic [4:0]  out_day_r;
  logic [4:0]  out_hour_r;
  logic [5:0]  out_minute_r;
  logic [5:0]  out_second_r;

  // Local time, clamped to the unsigned 32-bit range.
  assign off_sec   = offset_hours * 17'sd3600;
  assign local_sum = $signed({2'b00, in_epoch_seconds}) + {{17{off_sec[16]}}, off_sec};
  always_comb begin
    if (local_sum[33]) begin
      local_t = '0;
    end else if (local_sum[32]) begin
      local_t = '1;
    end else begin
      local_t = local_sum[31:0];
    end
  end

  // Day count in one step, the second of day from it in the next.
  assign prod_day  = 51'(lt_r[31:DAY_PRE_SHIFT]) * 51'(DAY_RECIP);
  assign day_start = 32'(quo_r) * 32'(DAY_SECONDS);

  assign prod_min  = 35'(rem_r) * 35'(MIN_RECIP);
  assign prod_hour = 22'(mins_r) * 22'(HOUR_RECIP);
  assign sec_full  = rem_r - 17'(mins_r) * 17'(MIN_SECONDS);
  assign min_full  = mins_r - 11'(hour_r) * 11'(MIN_SECONDS);

  assign leap     = ((c4_r == 2'd0) && (c100_r != 7'd0)) || (c400_r == 9'd0);
  assign year_len = leap ? 9'(LEAP_DAYS) : 9'(COMMON_DAYS);
  assign mstart   = month_start(mon_r) + {8'd0, leap && (mon_r > 4'(FEB_INDEX))};

  assign sts.year_done   = (quo_r < 16'(year_len));
  assign sts.month_found = (quo_r >= 16'(mstart));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lt_r   <= local_t;
      year_r <= 12'(FIRST_YEAR);
      c4_r   <= 2'(FIRST_MOD4);
      c100_r <= 7'(FIRST_MOD100);
      c400_r <= 9'(FIRST_MOD400);
      mon_r  <= 4'(LAST_MONTH);
    end
    if (cmd.day_div) begin
      quo_r <= prod_day[DAY_SHIFT+15:DAY_SHIFT];
    end
    if (cmd.sod_calc) begin
      rem_r <= 17'(lt_r - day_start);
    end
    if (cmd.hms1) begin
      mins_r <= prod_min[33:MIN_SHIFT];
    end
    if (cmd.hms2) begin
      hour_r <= prod_hour[20:HOUR_SHIFT];
      sec_r  <= sec_full[5:0];
    end
    if (cmd.hms3) begin
      min_r <= min_full[5:0];
    end
    if (cmd.year_step) begin
      quo_r  <= quo_r - 16'(year_len);
      year_r <= year_r + 12'd1;
      c4_r   <= c4_r + 2'd1;
      c100_r <= (c100_r == 7'd99) ? 7'd0 : c100_r + 7'd1;
      c400_r <= (c400_r == 9'd399) ? 9'd0 : c400_r + 9'd1;
    end
    if (cmd.month_step) begin
      if (sts.month_found) begin
        quo_r <= quo_r - 16'(mstart);
      end else begin
        mon_r <= mon_r - 4'd1;
      end
    end
    if (cmd.out_load) begin
      out_year_r   <= year_r;
      out_month_r  <= mon_r + 4'd1;
      out_day_r    <= quo_r[4:0] + 5'd1;
      out_hour_r   <= hour_r;
      out_minute_r <= min_r;
      out_second_r <= sec_r;
    end
  end

  assign out_year   = out_year_r;
  assign out_month  = out_month_r;
  assign out_day    = out_day_r;
  assign out_hour   = out_hour_r;
  assign out_minute = out_minute_r;
  assign out_second = out_second_r;

endmodule

FILE: src/epoch_seconds_to_calendar_top.sv
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_top
// Converts seconds since 1970-01-01 UTC into the local date and time, with a
// programmable whole-hour zone offset.
// ----------------------------------------------------------------------------
//  channel  | ports                          | word
//  input    | in_valid / in_ready            | epoch_seconds
//  result   | out_valid / out_ready          | year, month, day, hour, minute, second
//  config   | psel/penable/pwrite/paddr/...  | utc_offset_hours at byte address 0
//
// From acceptance to result a word passes the day division, the time-of-day
// split, the year walk and the month search; the year walk dominates.
// A new word is taken only while the sequencer is idle; a finished result sits
// in the output register, so the next word may start while it waits.
// Reset sets the zone offset to +8 hours and empties the output register.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_epoch_seconds,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [11:0] out_year,
  output logic [3:0]  out_month,
  output logic [4:0]  out_day,
  output logic [4:0]  out_hour,
  output logic [5:0]  out_minute,
  output logic [5:0]  out_second,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ets_pkg::*;

  ets_cmd_t          cmd;
  ets_sts_t          sts;
  logic signed [4:0] offset_r, offset_nxt;
  logic              reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == OFFSET_REG_IDX);

  always_comb begin
    offset_nxt = offset_r;
    if (psel && penable && pwrite && pready && reg_sel) begin
      offset_nxt = pwdata[4:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= 5'sd8;
    end else begin
      offset_r <= offset_nxt;
    end
  end

  assign prdata = reg_sel ? {27'd0, offset_r} : 32'd0;

  ets_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ets_dp u_dp (
    .clk              (clk),
    .cmd              (cmd),
    .sts              (sts),
    .offset_hours     (offset_r),
    .in_epoch_seconds (in_epoch_seconds),
    .out_year         (out_year),
    .out_month        (out_month),
    .out_day          (out_day),
    .out_hour         (out_hour),
    .out_minute       (out_minute),
    .out_second       (out_second)
  );

endmodule

FILE: src/ets_checker.sv
// ----------------------------------------------------------------------------
// ets_checker
// Port-level checks for the seconds-to-calendar converter, bound to the top.
// ----------------------------------------------------------------------------
module ets_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [11:0] out_year,
  input logic [3:0]  out_month,
  input logic [4:0]  out_day,
  input logic [4:0]  out_hour,
  input logic [5:0]  out_minute,
  input logic [5:0]  out_second
);

  // A word is converted step by step, so the input closes right after acceptance.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input still ready after a word was accepted");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable(out_year) && $stable(out_day)
                                  && $stable(out_second))
    else $error("result changed while stalled");

  a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_month >= 4'd1) && (out_month <= 4'd12) && (out_day >= 5'd1)
                  && (out_year >= 12'd1970) && (out_year <= 12'd2106))
    else $error("date field out of range");

  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hour <= 5'd23) && (out_minute <= 6'd59) && (out_second <= 6'd59))
    else $error("time field out of range");

endmodule

bind epoch_seconds_to_calendar_top ets_checker u_ets_checker (.*);

FILE: sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the seconds-to-calendar converter. A table of
// directed words runs first, then phases of random words, each phase under a
// new zone offset. Results are checked against the table or a local model.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 200;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASES       = 10;
  localparam int PHASE_WORDS  = 150;
  localparam int CALM_WORDS   = 200;
  localparam int SHOWN_MISSES = 10;
  localparam int NDIR         = 22;

  localparam logic [2:0] OFFSET_ADDR = 3'd0;
  localparam logic [2:0] UNUSED_ADDR = 3'd4;

  localparam logic [4:0] OFS_ZERO = 5'b00000;
  localparam logic [4:0] OFS_P8   = 5'b01000;
  localparam logic [4:0] OFS_P14  = 5'b01110;
  localparam logic [4:0] OFS_P15  = 5'b01111;
  localparam logic [4:0] OFS_M12  = 5'b10100;
  localparam logic [4:0] OFS_M16  = 5'b10000;

  localparam longint TOP_SECS = 64'd4294967295;

  // Days before each month of a common year, January at index 0.
  localparam logic [11:0][8:0] MONTH_START = {
    9'd334, 9'd304, 9'd273, 9'd243, 9'd212, 9'd181,
    9'd151, 9'd120, 9'd90,  9'd59,  9'd31,  9'd0
  };

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } cal_t;

  typedef struct packed {
    logic        wr;
    logic [2:0]  addr;
    logic [4:0]  ofs;
    logic [31:0] secs;
    logic        typed;
    cal_t        cal;
  } dir_row_t;

  localparam cal_t CAL_ZERO = '{12'd1970, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0};
  localparam cal_t CAL_TOP  = '{12'd2106, 4'd2, 5'd7, 5'd6, 6'd28, 6'd15};
  localparam cal_t CAL_NONE = '0;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_epoch_seconds = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [11:0] out_year;
  logic [3:0]  out_month;
  logic [4:0]  out_day;
  logic [4:0]  out_hour;
  logic [5:0]  out_minute;
  logic [5:0]  out_second;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  cal_t     cal_due[$];
  logic [4:0] tz_code = OFS_P8;
  bit       idle_on = 1'b1;
  int       miss_cnt = 0;
  int       quiet_cnt = 0;
  int       hold_cnt = 0;
  dir_row_t dir_tab [0:NDIR-1];
  cal_t     seen, want;

  epoch_seconds_to_calendar_top DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_epoch_seconds (in_epoch_seconds),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_year         (out_year),
    .out_month        (out_month),
    .out_day          (out_day),
    .out_hour         (out_hour),
    .out_minute       (out_minute),
    .out_second       (out_second),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always #2 clk = ~clk;

  function automatic bit leap_year(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic cal_t calendar_of(input logic [31:0] secs, input logic [4:0] tz);
    longint      lt;
    int unsigned t, days, sod, yr, ylen, mo, lp, start;
    cal_t        c;
    lt = longint'(secs) + longint'($signed(tz)) * 3600;
    if (lt < 0) lt = 0;
    if (lt > TOP_SECS) lt = TOP_SECS;
    t = lt[31:0];
    days = t / 86400;
    sod = t % 86400;
    yr = 1970;
    ylen = leap_year(yr) ? 366 : 365;
    while (days >= ylen) begin
      days -= ylen;
      yr++;
      ylen = leap_year(yr) ? 366 : 365;
    end
    lp = leap_year(yr) ? 1 : 0;
    // Every month after February starts one day later in a leap year.
    mo = 11;
    start = MONTH_START[mo] + lp;
    while (days < start) begin
      mo--;
      start = MONTH_START[mo] + ((mo >= 2) ? lp : 0);
    end
    days -= start;
    c.year   = yr[11:0];
    c.month  = 4'(mo + 1);
    c.day    = 5'(days + 1);
    c.hour   = 5'(sod / 3600);
    c.minute = 6'((sod / 60) % 60);
    c.second = 6'(sod % 60);
    return c;
  endfunction

  // Random word, mostly aimed at the places where the calendar rolls over.
  function automatic logic [31:0] pick_secs();
    logic [31:0] s;
    int unsigned yr, mo, days;
    int          sh;
    case ($urandom_range(0, 4))
      0: s = $urandom();
      1: s = $urandom_range(0, 200000);
      2: s = 32'hFFFF_FFFF - $urandom_range(0, 200000);
      3: s = $urandom_range(0, 49710) * 86400 + $urandom_range(0, 4) - 2;
      default: begin
        yr = $urandom_range(1970, 2106);
        mo = $urandom_range(0, 11);
        days = 0;
        for (int y = 1970; y < yr; y++) days += leap_year(y) ? 366 : 365;
        days += MONTH_START[mo] + ((mo >= 2 && leap_year(yr)) ? 1 : 0);
        // Land the local time, not the UTC time, next to the boundary.
        sh = $signed(tz_code) * 3600;
        s = days * 86400 - sh + $urandom_range(0, 4) - 2;
      end
    endcase
    return s;
  endfunction

  task automatic send_word(input logic [31:0] secs, input logic typed, input cal_t cal);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_epoch_seconds <= secs;
    do @(posedge clk); while (!in_ready);
    cal_due.push_back(typed ? cal : calendar_of(secs, tz_code));
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [4:0] val);
    logic [31:0] w;
    in_valid <= 1'b0;
    while (cal_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    w = $urandom();
    w[4:0] = val;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= w;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == OFFSET_ADDR) tz_code = val;
  endtask

  task automatic note_miss(input string what, input int e, input int a);
    if (miss_cnt < SHOWN_MISSES)
      $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, e, a);
    miss_cnt++;
  endtask

  // Result side stalls in bursts while idling is enabled.
  always @(posedge clk) begin
    if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      out_ready <= 1'b0;
      hold_cnt <= $urandom_range(0, 13);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      seen = '{out_year, out_month, out_day, out_hour, out_minute, out_second};
      if (cal_due.size() == 0) begin
        note_miss("unexpected word, year", 0, int'(seen.year));
      end else begin
        want = cal_due.pop_front();
        if (want.year !== seen.year) note_miss("year", int'(want.year), int'(seen.year));
        if (want.month !== seen.month) note_miss("month", int'(want.month), int'(seen.month));
        if (want.day !== seen.day) note_miss("day", int'(want.day), int'(seen.day));
        if (want.hour !== seen.hour) note_miss("hour", int'(want.hour), int'(seen.hour));
        if (want.minute !== seen.minute)
          note_miss("minute", int'(want.minute), int'(seen.minute));
        if (want.second !== seen.second)
          note_miss("second", int'(want.second), int'(seen.second));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || psel) begin
      quiet_cnt <= 0;
    end else if (quiet_cnt >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cnt <= quiet_cnt + 1;
    end
  end

  initial begin
    logic [4:0] ofs;
    int         sent;
    dir_tab = '{
      // After reset the offset is +8 hours.
      '{1'b0, OFFSET_ADDR, OFS_P8,   32'd0,          1'b1, '{12'd1970, 4'd1, 5'd1, 5'd8, 6'd0, 6'd0}},
      '{1'b0, OFFSET_ADDR, OFS_P8,   32'hFFFF_FFFF,  1'b1, CAL_TOP},
      '{1'b0, OFFSET_ADDR, OFS_P8,   32'd4294938495, 1'b0, CAL_NONE},
      '{1'b1, OFFSET_ADDR, OFS_ZERO, 32'd0,          1'b1, CAL_ZERO},
      '{1'b0, OFFSET_ADDR, OFS_ZERO, 32'hFFFF_FFFF,  1'b1, CAL_TOP},
      // Leap day of a 400th year, the day after it and the year end before.
      '{1'b0, OFFSET_ADDR, OFS_ZERO, 32'd951782400,  1'b0, CAL_NONE},
      '{1'b0, OFFSET_ADDR, OFS_ZERO, 32'd951868800,  1'b0, CAL_NONE},
      '{1'b0, OFFSET_ADDR, OFS_ZERO, 32'd946684799,  1'b0, CAL_NONE},
      // 2100 is a century year without a leap day.
      '{1'b0, OFFSET_ADDR, OFS_ZERO, 32'd4107542399, 1'b0, CAL_NONE},
      '{1'b0, OFFSET_ADDR, OFS_ZERO, 32'd68169600,   1'b0, CAL_NONE},
      '{1'b0, OFFSET_ADDR, OFS_ZERO, 32'd94607999,   1'b0, CAL_NONE},
      // Negative offsets clamp the local time at zero.
      '{1'b1, OFFSET_ADDR, OFS_M12,  32'd0,          1'b1, CAL_ZERO},
      '{1'b0, OFFSET_ADDR, OFS_M12,  32'd43199,      1'b1, CAL_ZERO},
      '{1'b0, OFFSET_ADDR, OFS_M12,  32'd43200,      1'b1, CAL_ZERO},
      '{1'b1, OFFSET_ADDR, OFS_M16,  32'd57599,      1'b1, CAL_ZERO},
      '{1'b0, OFFSET_ADDR, OFS_M16,  32'hFFFF_FFFF,  1'b0, CAL_NONE},
      '{1'b1, OFFSET_ADDR, OFS_P15,  32'hFFFF_FFFF,  1'b1, CAL_TOP},
      '{1'b0, OFFSET_ADDR, OFS_P15,  32'd0,          1'b1, '{12'd1970, 4'd1, 5'd1, 5'd15, 6'd0, 6'd0}},
      '{1'b1, OFFSET_ADDR, OFS_P14,  32'd1,          1'b0, CAL_NONE},
      // A write to an unused address leaves the offset alone.
      '{1'b1, UNUSED_ADDR, OFS_ZERO, 32'd86399,      1'b0, CAL_NONE},
      '{1'b0, OFFSET_ADDR, OFS_P14,  32'h5555_5555,  1'b0, CAL_NONE},
      '{1'b0, OFFSET_ADDR, OFS_P14,  32'hAAAA_AAAA,  1'b0, CAL_NONE}
    };
    sent = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < NDIR; i++) begin
      if (dir_tab[i].wr) write_reg(dir_tab[i].addr, dir_tab[i].ofs);
      send_word(dir_tab[i].secs, dir_tab[i].typed, dir_tab[i].cal);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        1:       ofs = OFS_M16;
        2:       ofs = OFS_P15;
        3:       ofs = OFS_M12;
        4:       ofs = OFS_P14;
        default: ofs = 5'($urandom_range(0, 31));
      endcase
      if (ph == 5) write_reg(UNUSED_ADDR, 5'($urandom_range(0, 31)));
      write_reg(OFFSET_ADDR, ofs);
      for (int k = 0; k < PHASE_WORDS; k++) begin
        idle_on = (sent < PHASES * PHASE_WORDS - CALM_WORDS);
        send_word(pick_secs(), 1'b0, CAL_NONE);
        sent++;
      end
    end

    in_valid <= 1'b0;
    while (cal_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (miss_cnt == 0 && cal_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: epoch_seconds_to_calendar_top.f
src/ets_pkg.sv
src/ets_ctrl.sv
src/ets_dp.sv
src/epoch_seconds_to_calendar_top.sv
src/ets_checker.sv
sim/tb_top.sv
